FILE: rtl/rgbhsv_pkg.sv
`default_nettype none

package rgbhsv_pkg;

    // Fixed-point scaling of the results
    localparam int HUE_FRAC_BITS = 4;
    localparam int SAT_FRAC_BITS = 12;

    // Field widths
    localparam int CH_W  = 8;
    localparam int HUE_W = 13;
    localparam int SAT_W = 13;

    // Hue constants in output units
    localparam int HUE_SCALE  = 60 << HUE_FRAC_BITS;
    localparam int HUE_FULL   = 360 << HUE_FRAC_BITS;
    localparam int HUE_GREEN  = 120 << HUE_FRAC_BITS;
    localparam int HUE_BLUE   = 240 << HUE_FRAC_BITS;

    // Numerator widths of the two quotients
    localparam int SNUM_W = CH_W + SAT_FRAC_BITS;
    localparam int HNUM_W = $clog2(255 * HUE_SCALE + 255 + 1);
    localparam int NUM_W  = (SNUM_W > HNUM_W) ? SNUM_W : HNUM_W;

    // Reciprocal table: ceil(2^RECIP_SHIFT / x), exact for numerators below 2^NUM_W
    localparam int RECIP_SHIFT = NUM_W + CH_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int REM_W       = CH_W + 2;

    // Width of the hue sum before the wrap
    localparam int HSUM_W = $clog2(2 * HUE_FULL);

    typedef logic [RECIP_W-1:0] recip_tbl_t [256];

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // Stage 1 result: extremes and hue difference
    typedef struct packed {
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] diff;
        logic            neg;
        logic [CH_W-1:0] dmag;
        sector_t         sector;
        logic            fe;
    } front_t;

    // Stage 3 result: both quotients
    typedef struct packed {
        logic [SNUM_W-1:0] q_sat;
        logic [HNUM_W-1:0] q_hue;
        logic              neg;
        sector_t           sector;
        logic [CH_W-1:0]   mx;
        logic              fe;
    } quot_t;

    // Stage enables for the divider stages
    typedef struct packed {
        logic s2_en;
        logic s3_en;
    } div_ctl_t;

    // Build the reciprocal table by long division
    function automatic recip_tbl_t build_recip();
        recip_tbl_t       tbl;
        logic [RECIP_W-1:0] num;
        logic [RECIP_W-1:0] quo;
        logic [REM_W-1:0]   rem;
        tbl[0] = '0;
        for (int x = 1; x < 256; x++) begin
            num = RECIP_W'(1) << RECIP_SHIFT;
            num = num + RECIP_W'(x - 1);
            rem = '0;
            quo = '0;
            for (int i = RECIP_W - 1; i >= 0; i--) begin
                rem = {rem[REM_W-2:0], num[i]};
                if (rem >= REM_W'(x)) begin
                    rem    = rem - REM_W'(x);
                    quo[i] = 1'b1;
                end
            end
            tbl[x] = quo;
        end
        return tbl;
    endfunction

    localparam recip_tbl_t RECIP_TBL = build_recip();

endpackage

`default_nettype wire

FILE: rtl/rgb_to_hsv.sv
// Each pixel passes through four register stages in order: extremes, reciprocal
// lookup, reciprocal multiply, and the hue-wrap output register.
// Throughput: one pixel per cycle unless m_ready back-pressure stalls the
// pipeline; each of the stages has its own valid bit.
// Reset: synchronous active-low aresetn clears all stage valid bits; the
// data registers are not reset.
`default_nettype none

module rgb_to_hsv (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output      logic                        s_ready,
    input  wire logic [rgbhsv_pkg::CH_W-1:0] s_red,
    input  wire logic [rgbhsv_pkg::CH_W-1:0] s_green,
    input  wire logic [rgbhsv_pkg::CH_W-1:0] s_blue,
    input  wire logic                        s_frame_end,
    output      logic                        m_valid,
    input  wire logic                        m_ready,
    output      logic [rgbhsv_pkg::HUE_W-1:0] m_hue,
    output      logic [rgbhsv_pkg::SAT_W-1:0] m_saturation,
    output      logic [rgbhsv_pkg::CH_W-1:0]  m_brightness,
    output      logic                        m_frame_end_out
);

    localparam int HSUM_W = rgbhsv_pkg::HSUM_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic en1, en2, en3, en4;

    rgbhsv_pkg::front_t   front;
    rgbhsv_pkg::quot_t    quot;
    rgbhsv_pkg::div_ctl_t div_ctl;

    logic [HSUM_W-1:0]          offset;
    logic [HSUM_W-1:0]          hsum;
    logic [HSUM_W-1:0]          hwrap;

    logic [rgbhsv_pkg::HUE_W-1:0] hue_reg;
    logic [rgbhsv_pkg::HUE_W-1:0] hue_next;
    logic [rgbhsv_pkg::SAT_W-1:0] sat_reg;
    logic [rgbhsv_pkg::SAT_W-1:0] sat_next;
    logic [rgbhsv_pkg::CH_W-1:0]  val_reg;
    logic                         fe_reg;

    // Stage enables: a stage loads when empty or when the next one moves
    assign en4 = !v4_reg || m_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_ready = en1;

    assign v1_next = en1 ? s_valid : v1_reg;
    assign v2_next = en2 ? v1_reg  : v2_reg;
    assign v3_next = en3 ? v2_reg  : v3_reg;
    assign v4_next = en4 ? v3_reg  : v4_reg;

    // Hold or advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    rgbhsv_front u_front (
        .aclk      (aclk),
        .en        (en1),
        .red       (s_red),
        .green     (s_green),
        .blue      (s_blue),
        .frame_end (s_frame_end),
        .front     (front)
    );

    assign div_ctl.s2_en = en2;
    assign div_ctl.s3_en = en3;

    rgbhsv_div u_div (
        .aclk  (aclk),
        .ctl   (div_ctl),
        .front (front),
        .quot  (quot)
    );

    // Add the sector offset to the signed quotient and wrap once
    always_comb begin
        case (quot.sector)
            rgbhsv_pkg::SEC_RED:   offset = HSUM_W'(rgbhsv_pkg::HUE_FULL);
            rgbhsv_pkg::SEC_GREEN: offset = HSUM_W'(rgbhsv_pkg::HUE_GREEN);
            rgbhsv_pkg::SEC_BLUE:  offset = HSUM_W'(rgbhsv_pkg::HUE_BLUE);
            default:               offset = HSUM_W'(rgbhsv_pkg::HUE_FULL);
        endcase
        if (quot.neg) begin
            hsum = offset - HSUM_W'(quot.q_hue);
        end else begin
            hsum = offset + HSUM_W'(quot.q_hue);
        end
        if (hsum >= HSUM_W'(rgbhsv_pkg::HUE_FULL)) begin
            hwrap = hsum - HSUM_W'(rgbhsv_pkg::HUE_FULL);
        end else begin
            hwrap = hsum;
        end
        hue_next = rgbhsv_pkg::HUE_W'(hwrap);
        sat_next = rgbhsv_pkg::SAT_W'(quot.q_sat);
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (en4) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= quot.mx;
            fe_reg  <= quot.fe;
        end
    end

    assign m_valid         = v4_reg;
    assign m_hue           = hue_reg;
    assign m_saturation    = sat_reg;
    assign m_brightness    = val_reg;
    assign m_frame_end_out = fe_reg;

endmodule

`default_nettype wire

FILE: rtl/rgbhsv_front.sv
`default_nettype none

module rgbhsv_front (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [rgbhsv_pkg::CH_W-1:0] red,
    input  wire logic [rgbhsv_pkg::CH_W-1:0] green,
    input  wire logic [rgbhsv_pkg::CH_W-1:0] blue,
    input  wire logic                      frame_end,
    output rgbhsv_pkg::front_t             front
);

    rgbhsv_pkg::front_t front_reg;
    rgbhsv_pkg::front_t front_next;

    logic [rgbhsv_pkg::CH_W-1:0] mn;
    logic [rgbhsv_pkg::CH_W-1:0] da;
    logic [rgbhsv_pkg::CH_W-1:0] db;

    // Pick the largest channel, red over green over blue on ties
    always_comb begin
        if (red >= green && red >= blue) begin
            front_next.mx     = red;
            front_next.sector = rgbhsv_pkg::SEC_RED;
            da                = green;
            db                = blue;
        end else if (green >= blue) begin
            front_next.mx     = green;
            front_next.sector = rgbhsv_pkg::SEC_GREEN;
            da                = blue;
            db                = red;
        end else begin
            front_next.mx     = blue;
            front_next.sector = rgbhsv_pkg::SEC_BLUE;
            da                = red;
            db                = green;
        end

        mn = red;
        if (green < mn) begin
            mn = green;
        end
        if (blue < mn) begin
            mn = blue;
        end

        front_next.diff = front_next.mx - mn;
        front_next.neg  = (da < db);
        front_next.dmag = front_next.neg ? (db - da) : (da - db);
        front_next.fe   = frame_end;
    end

    // Advance stage 1
    always_ff @(posedge aclk) begin
        if (en) begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

`default_nettype wire

FILE: rtl/rgbhsv_div.sv
`default_nettype none

module rgbhsv_div (
    input  wire logic                aclk,
    input  wire rgbhsv_pkg::div_ctl_t ctl,
    input  wire rgbhsv_pkg::front_t  front,
    output rgbhsv_pkg::quot_t        quot
);

    localparam int SNUM_W  = rgbhsv_pkg::SNUM_W;
    localparam int HNUM_W  = rgbhsv_pkg::HNUM_W;
    localparam int RECIP_W = rgbhsv_pkg::RECIP_W;
    localparam int SHIFT   = rgbhsv_pkg::RECIP_SHIFT;
    localparam int CH_W    = rgbhsv_pkg::CH_W;

    // Stage 2 registers
    logic [SNUM_W-1:0]   snum_reg;
    logic [HNUM_W-1:0]   hnum_reg;
    logic [RECIP_W-1:0]  rsat_reg;
    logic [RECIP_W-1:0]  rhue_reg;
    logic                neg_reg;
    rgbhsv_pkg::sector_t sector_reg;
    logic [CH_W-1:0]     mx_reg;
    logic                fe_reg;

    logic [SNUM_W-1:0]   snum_next;
    logic [HNUM_W-1:0]   hnum_next;
    logic [RECIP_W-1:0]  rsat_next;
    logic [RECIP_W-1:0]  rhue_next;

    rgbhsv_pkg::quot_t   quot_reg;
    rgbhsv_pkg::quot_t   quot_next;

    logic [SNUM_W+RECIP_W-1:0] sat_prod;
    logic [HNUM_W+RECIP_W-1:0] hue_prod;

    // Look up reciprocals and form numerators; a negative difference gets
    // d-1 added so the quotient becomes the ceiling
    always_comb begin
        snum_next = {front.diff, {rgbhsv_pkg::SAT_FRAC_BITS{1'b0}}};
        hnum_next = HNUM_W'(front.dmag) * HNUM_W'(rgbhsv_pkg::HUE_SCALE);
        if (front.neg) begin
            hnum_next = hnum_next + HNUM_W'(front.diff) - HNUM_W'(1);
        end
        rsat_next = rgbhsv_pkg::RECIP_TBL[front.mx];
        rhue_next = rgbhsv_pkg::RECIP_TBL[front.diff];
    end

    // Advance stage 2
    always_ff @(posedge aclk) begin
        if (ctl.s2_en) begin
            snum_reg   <= snum_next;
            hnum_reg   <= hnum_next;
            rsat_reg   <= rsat_next;
            rhue_reg   <= rhue_next;
            neg_reg    <= front.neg;
            sector_reg <= front.sector;
            mx_reg     <= front.mx;
            fe_reg     <= front.fe;
        end
    end

    // Multiply by the reciprocal and keep the integer part
    always_comb begin
        sat_prod = (SNUM_W + RECIP_W)'(snum_reg) * (SNUM_W + RECIP_W)'(rsat_reg);
        hue_prod = (HNUM_W + RECIP_W)'(hnum_reg) * (HNUM_W + RECIP_W)'(rhue_reg);
        quot_next.q_sat  = sat_prod[SHIFT +: SNUM_W];
        quot_next.q_hue  = hue_prod[SHIFT +: HNUM_W];
        quot_next.neg    = neg_reg;
        quot_next.sector = sector_reg;
        quot_next.mx     = mx_reg;
        quot_next.fe     = fe_reg;
    end

    // Advance stage 3
    always_ff @(posedge aclk) begin
        if (ctl.s3_en) begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

FILE: test/hsv_checker.sv
`timescale 1ns / 100ps

module hsv_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [rgbhsv_pkg::CH_W-1:0]    s_red,
    input  logic [rgbhsv_pkg::CH_W-1:0]    s_green,
    input  logic [rgbhsv_pkg::CH_W-1:0]    s_blue,
    input  logic                           s_frame_end,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [rgbhsv_pkg::HUE_W-1:0]   m_hue,
    input  logic [rgbhsv_pkg::SAT_W-1:0]   m_saturation,
    input  logic [rgbhsv_pkg::CH_W-1:0]    m_brightness,
    input  logic                           m_frame_end_out,
    input  logic                           run_done,
    output int                             fail_count,
    output int                             pending
);

    typedef struct {
        logic [rgbhsv_pkg::HUE_W-1:0] hue;
        logic [rgbhsv_pkg::SAT_W-1:0] sat;
        logic [rgbhsv_pkg::CH_W-1:0]  bright;
        logic                         fe;
    } hsv_pixel_t;

    hsv_pixel_t hsv_queue[$];
    hsv_pixel_t want_px;
    bit         leftover_flagged;

    // Convert one RGB pixel into the HSV fields the block should return
    function automatic hsv_pixel_t hsv_predict(input logic [rgbhsv_pkg::CH_W-1:0] r,
                                               input logic [rgbhsv_pkg::CH_W-1:0] g,
                                               input logic [rgbhsv_pkg::CH_W-1:0] b,
                                               input logic fe);
        hsv_pixel_t px;
        int mx, mn, diff, delta, offset, num, quo, unit, hue, sat;
        unit = 1 << rgbhsv_pkg::HUE_FRAC_BITS;
        mx = (r > g) ? r : g;
        mn = (r < g) ? r : g;
        if (b > mx) mx = b;
        if (b < mn) mn = b;
        diff = mx - mn;
        hue = 0;
        sat = 0;
        if (diff != 0) begin
            // Largest channel picks the sector; red wins ties, then green
            if (mx == r) begin
                delta  = int'(g) - int'(b);
                offset = 360 * unit;
            end else if (mx == g) begin
                delta  = int'(b) - int'(r);
                offset = 120 * unit;
            end else begin
                delta  = int'(r) - int'(g);
                offset = 240 * unit;
            end
            num = 60 * unit * delta;
            // Floor division toward minus infinity
            if (num >= 0) quo = num / diff;
            else          quo = -((-num + diff - 1) / diff);
            hue = (quo + offset) % (360 * unit);
        end
        if (mx != 0) sat = (diff << rgbhsv_pkg::SAT_FRAC_BITS) / mx;
        px.hue    = rgbhsv_pkg::HUE_W'(hue);
        px.sat    = rgbhsv_pkg::SAT_W'(sat);
        px.bright = rgbhsv_pkg::CH_W'(mx);
        px.fe     = fe;
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Predict on every input transfer, compare on every result transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            hsv_queue.delete();
            fail_count = 0;
            leftover_flagged = 0;
        end else begin
            if (s_valid && s_ready)
                hsv_queue.push_back(hsv_predict(s_red, s_green, s_blue, s_frame_end));
            if (m_valid && m_ready) begin
                if (hsv_queue.size() == 0) begin
                    report_mismatch("result transfer with no pixel outstanding");
                end else begin
                    want_px = hsv_queue.pop_front();
                    if (m_hue !== want_px.hue)
                        report_mismatch($sformatf("hue: got %0d, want %0d", m_hue, want_px.hue));
                    if (m_saturation !== want_px.sat)
                        report_mismatch($sformatf("saturation: got %0d, want %0d",
                                                  m_saturation, want_px.sat));
                    if (m_brightness !== want_px.bright)
                        report_mismatch($sformatf("brightness: got %0d, want %0d",
                                                  m_brightness, want_px.bright));
                    if (m_frame_end_out !== want_px.fe)
                        report_mismatch($sformatf("frame_end_out: got %0b, want %0b",
                                                  m_frame_end_out, want_px.fe));
                end
            end
            // Flag results that never arrived
            if (run_done && !leftover_flagged && hsv_queue.size() != 0) begin
                report_mismatch($sformatf("%0d results never arrived", hsv_queue.size()));
                leftover_flagged = 1;
            end
        end
        pending = hsv_queue.size();
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int NUM_RANDOM = 1400;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [rgbhsv_pkg::CH_W-1:0]    s_red;
    logic [rgbhsv_pkg::CH_W-1:0]    s_green;
    logic [rgbhsv_pkg::CH_W-1:0]    s_blue;
    logic                           s_frame_end;
    logic                           m_valid;
    logic                           m_ready;
    logic [rgbhsv_pkg::HUE_W-1:0]   m_hue;
    logic [rgbhsv_pkg::SAT_W-1:0]   m_saturation;
    logic [rgbhsv_pkg::CH_W-1:0]    m_brightness;
    logic                           m_frame_end_out;
    logic                           run_done;
    int                             fail_count;
    int                             pending;
    bit                             burst;

    rgb_to_hsv u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_red           (s_red),
        .s_green         (s_green),
        .s_blue          (s_blue),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hue           (m_hue),
        .m_saturation    (m_saturation),
        .m_brightness    (m_brightness),
        .m_frame_end_out (m_frame_end_out)
    );

    hsv_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_red           (s_red),
        .s_green         (s_green),
        .s_blue          (s_blue),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hue           (m_hue),
        .m_saturation    (m_saturation),
        .m_brightness    (m_brightness),
        .m_frame_end_out (m_frame_end_out),
        .run_done        (run_done),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5ms;
        $display("rgb_to_hsv: mismatch");
        $finish;
    end

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    // Offer one pixel after a random gap and hold it until the transfer
    task automatic send_pixel(input logic [rgbhsv_pkg::CH_W-1:0] r,
                              input logic [rgbhsv_pkg::CH_W-1:0] g,
                              input logic [rgbhsv_pkg::CH_W-1:0] b,
                              input logic fe);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_red       <= r;
        s_green     <= g;
        s_blue      <= b;
        s_frame_end <= fe;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stall the result side for a random number of cycles per transfer
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        logic [rgbhsv_pkg::CH_W-1:0] r, g, b, lo;
        logic                        fe;
        int                          kind;

        s_valid     <= 1'b0;
        s_red       <= '0;
        s_green     <= '0;
        s_blue      <= '0;
        s_frame_end <= 1'b0;
        run_done    <= 1'b0;
        burst        = 0;
        aresetn     <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn     <= 1'b1;
        @(posedge aclk);

        // Directed: black, white, greys, primaries, ties, hue wrap, flag
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd1,   8'd1,   8'd1,   1'b0);
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   1'b1);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd255, 1'b0);
        send_pixel(8'd200, 8'd200, 8'd100, 1'b1);
        send_pixel(8'd255, 8'd0,   8'd1,   1'b0);
        send_pixel(8'd255, 8'd1,   8'd0,   1'b0);
        send_pixel(8'd1,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd1,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd1,   1'b0);
        send_pixel(8'd255, 8'd254, 8'd254, 1'b0);
        send_pixel(8'd254, 8'd255, 8'd0,   1'b1);
        send_pixel(8'd1,   8'd0,   8'd255, 1'b0);
        send_pixel(8'd0,   8'd255, 8'd1,   1'b0);
        send_pixel(8'd170, 8'd85,  8'd255, 1'b0);
        send_pixel(8'd37,  8'd150, 8'd211, 1'b1);

        // Random pixels: half uniform, plus greys, ties, near-greys, 0/255 red and green, and very dark pixels
        for (int i = 0; i < NUM_RANDOM; i++) begin
            burst = (i % 300) < 40;
            kind = $urandom_range(0, 9);
            r  = $urandom_range(0, 255);
            g  = $urandom_range(0, 255);
            b  = $urandom_range(0, 255);
            fe = ($urandom_range(0, 15) == 0);
            case (kind)
                5: begin
                    g = r;
                    b = r;
                end
                6: begin
                    // Two channels tie for the top
                    case ($urandom_range(0, 2))
                        0: begin g = r; b = $urandom_range(0, r); end
                        1: begin b = g; r = $urandom_range(0, g); end
                        default: begin b = r; g = $urandom_range(0, r); end
                    endcase
                end
                7: begin
                    lo = $urandom_range(0, 251);
                    r = lo + rgbhsv_pkg::CH_W'($urandom_range(0, 4));
                    g = lo + rgbhsv_pkg::CH_W'($urandom_range(0, 4));
                    b = lo + rgbhsv_pkg::CH_W'($urandom_range(0, 4));
                end
                8: begin
                    r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    if ($urandom_range(0, 1)) g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                end
                9: begin
                    r = $urandom_range(0, 3);
                    g = $urandom_range(0, 3);
                    b = $urandom_range(0, 3);
                end
                default: ;
            endcase
            send_pixel(r, g, b, fe);
        end
        burst = 0;

        // Drain: wait for every result before flagging the run done
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        run_done <= 1'b1;
        repeat (2) @(posedge aclk);

        if (fail_count == 0) begin
            $display("rgb_to_hsv: match");
        end else begin
            $display("rgb_to_hsv: mismatch");
        end
        $finish;
    end

endmodule
